>>> design/rled_pkg.sv
// Shared types and constants for the run-length packet decoder.
// No dependencies; used by rled_core, rle_packet_decoder, rled_stream_checker and the testbench.
`timescale 1ns / 1ps

package rled_pkg;

	localparam logic [31:0] MAGIC_VALUE = 32'h21494D46;
	localparam int unsigned LEN_BITS = 7;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CONTROL = 3'd1,
		PH_LITERAL = 3'd2,
		PH_REPEAT  = 3'd3,
		PH_DRAIN   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_DATA     = 3'd0,
		ST_OK       = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_MISMATCH = 3'd4,
		ST_TRUNC    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] value;
		logic [7:0] count;
		status_t    status;
		logic       finished;
	} result_t;

endpackage

>>> design/rled_core.sv
// Decoder state and single-step update: header parse, packet decode, status.
// Depends on rled_pkg.
`timescale 1ns / 1ps

module rled_core import rled_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output logic       have,
	output result_t    res
);

	phase_t      phase_q, phase_nxt;
	logic [3:0]  hdr_idx_q, hdr_idx_nxt;
	logic [31:0] magic_q, magic_nxt;
	logic [31:0] pkts_q, pkts_nxt;
	logic [63:0] exp_q, exp_nxt;
	logic [63:0] prod_q, prod_nxt;
	logic [7:0]  run_q, run_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_idx_q <= '0;
			magic_q   <= '0;
			pkts_q    <= '0;
			exp_q     <= '0;
			prod_q    <= '0;
			run_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_nxt;
			hdr_idx_q <= hdr_idx_nxt;
			magic_q   <= magic_nxt;
			pkts_q    <= pkts_nxt;
			exp_q     <= exp_nxt;
			prod_q    <= prod_nxt;
			run_q     <= run_nxt;
		end
	end

	logic [63:0] room;
	logic        full;
	logic        room_short;
	logic [4:0]  lane;

	always_comb begin
		room       = exp_q - prod_q;
		full       = (prod_q >= exp_q);
		room_short = (room[63:8] == '0) && (room[7:0] < run_q);
		lane       = {hdr_idx_q[1:0], 3'b000};

		phase_nxt   = phase_q;
		hdr_idx_nxt = hdr_idx_q;
		magic_nxt   = magic_q;
		pkts_nxt    = pkts_q;
		exp_nxt     = exp_q;
		prod_nxt    = prod_q;
		run_nxt     = run_q;
		have        = 1'b0;
		res         = '{value: 8'd0, count: 8'd0, status: ST_DATA, finished: 1'b0};

		unique case (phase_q)
			PH_HEADER: begin
				unique case (hdr_idx_q[3:2])
					2'b00:   magic_nxt[lane +: 8] = in_byte;
					2'b01:   pkts_nxt[lane +: 8] = in_byte;
					default: exp_nxt[{hdr_idx_q[2:0], 3'b000} +: 8] = in_byte;
				endcase
				if (hdr_idx_q == 4'd15) begin
					hdr_idx_nxt = '0;
					if (magic_nxt != MAGIC_VALUE) begin
						have = 1'b1;
						res.finished = 1'b1;
						res.status = ST_MAGIC;
					end else if (pkts_nxt == '0) begin
						have = 1'b1;
						res.finished = 1'b1;
						res.status = (exp_nxt == '0) ? ST_OK : ST_MISMATCH;
					end else begin
						phase_nxt = PH_CONTROL;
					end
				end else begin
					hdr_idx_nxt = hdr_idx_q + 4'd1;
				end
			end
			PH_CONTROL: begin
				pkts_nxt = pkts_q - 32'd1;
				run_nxt  = {1'b0, in_byte[LEN_BITS-1:0]} + 8'd1;
				if (in_byte[LEN_BITS]) begin
					phase_nxt = PH_REPEAT;
				end else if (full) begin
					have = 1'b1;
					res.finished = 1'b1;
					res.status = ST_OVERFLOW;
				end else begin
					phase_nxt = PH_LITERAL;
				end
			end
			PH_LITERAL: begin
				have = 1'b1;
				if (full) begin
					res.finished = 1'b1;
					res.status = ST_OVERFLOW;
				end else begin
					res.value = in_byte;
					res.count = 8'd1;
					prod_nxt  = prod_q + 64'd1;
					run_nxt   = run_q - 8'd1;
					if (run_q == 8'd1) begin
						if (pkts_q == '0) begin
							res.finished = 1'b1;
							res.status = (prod_nxt == exp_q) ? ST_OK : ST_MISMATCH;
						end else begin
							phase_nxt = PH_CONTROL;
						end
					end
				end
			end
			PH_REPEAT: begin
				have    = 1'b1;
				run_nxt = '0;
				if (room == '0) begin
					res.finished = 1'b1;
					res.status = ST_OVERFLOW;
				end else if (room_short) begin
					// clip to what the original size still allows
					res.value = in_byte;
					res.count = room[7:0];
					prod_nxt  = exp_q;
					res.finished = 1'b1;
					res.status = ST_OVERFLOW;
				end else begin
					res.value = in_byte;
					res.count = run_q;
					prod_nxt  = prod_q + {56'd0, run_q};
					if (pkts_q == '0) begin
						res.finished = 1'b1;
						res.status = (prod_nxt == exp_q) ? ST_OK : ST_MISMATCH;
					end else begin
						phase_nxt = PH_CONTROL;
					end
				end
			end
			PH_DRAIN: begin
			end
			default: begin
			end
		endcase

		// end of file on a byte that does not close decoding
		if (end_of_file && phase_q != PH_DRAIN && !res.finished) begin
			have = 1'b1;
			res.finished = 1'b1;
			res.status = ST_TRUNC;
		end

		if (end_of_file) begin
			phase_nxt   = PH_HEADER;
			hdr_idx_nxt = '0;
			magic_nxt   = '0;
			pkts_nxt    = '0;
			exp_nxt     = '0;
			prod_nxt    = '0;
			run_nxt     = '0;
		end else if (res.finished) begin
			phase_nxt = PH_DRAIN;
		end
	end

endmodule

>>> design/rle_packet_decoder.sv
// Run-length packet decoder top: input register, decode step, result register.
// A transferred byte is held in the input register, decoded, and its result held in the result register.
// Throughput: one byte per cycle while results are taken; the decode step is a single pass per byte.
// Ready drops only while a held result is not taken.
// Reset (arst_n low, asynchronous): header parsing, all counters zero, no result.
// Depends on rled_pkg and rled_core.
`timescale 1ns / 1ps

module rle_packet_decoder import rled_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_value,
	output logic [7:0] out_count,
	output logic [2:0] status,
	output logic       finished
);

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       eof_s1;

	logic       out_valid_q;
	result_t    res_q;

	logic       out_free;
	logic       step;
	logic       have;
	result_t    res;

	assign out_free = !out_valid_q || out_ready;
	assign step     = in_valid_s1 && out_free;
	assign in_ready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_byte_s1 <= in_byte;
			eof_s1     <= end_of_file;
		end
	end

	rled_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.in_byte     (in_byte_s1),
		.end_of_file (eof_s1),
		.have        (have),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= have;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk) begin
		if (step && have) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = res_q.value;
	assign out_count = res_q.count;
	assign status    = res_q.status;
	assign finished  = res_q.finished;

endmodule

>>> sim/rled_stream_checker.sv
// Scoreboard for the run-length packet decoder: tracks the decode state on every byte
// transfer, queues the tokens the block owes and checks each result transfer in order.
// Depends on rled_pkg.
`timescale 1ns / 1ps

module rled_stream_checker import rled_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_value,
	input  logic [7:0] out_count,
	input  logic [2:0] status,
	input  logic       finished,
	output int         mismatches,
	output int         tokens_due_n,
	output int         tokens_seen
);

	phase_t      phase;
	logic [3:0]  hdr_idx;
	logic [31:0] magic;
	logic [31:0] packets_left;
	logic [63:0] size_goal;
	logic [63:0] size_made;
	logic [7:0]  run_left;
	result_t     tokens_due[$];
	int          bad_n = 0;
	int          seen_n = 0;

	task automatic clear_state();
		phase = PH_HEADER;
		hdr_idx = '0;
		magic = '0;
		packets_left = '0;
		size_goal = '0;
		size_made = '0;
		run_left = '0;
	endtask

	function automatic status_t size_verdict();
		return (size_made == size_goal) ? ST_OK : ST_MISMATCH;
	endfunction

	// Advance the decode state by one byte; queue the token it yields, if any.
	task automatic decode_byte(input logic [7:0] b, input logic eof);
		result_t     tok;
		logic        have;
		logic        fin;
		status_t     st;
		logic [63:0] room;
		have = 1'b0;
		fin = 1'b0;
		st = ST_DATA;
		tok.value = '0;
		tok.count = '0;
		case (phase)
			PH_HEADER: begin
				if (hdr_idx < 4)
					magic[8 * hdr_idx +: 8] = magic[8 * hdr_idx +: 8] | b;
				else if (hdr_idx < 8)
					packets_left[8 * (hdr_idx - 4) +: 8] =
						packets_left[8 * (hdr_idx - 4) +: 8] | b;
				else
					size_goal[8 * (hdr_idx - 8) +: 8] = size_goal[8 * (hdr_idx - 8) +: 8] | b;
				if (hdr_idx == 4'd15) begin
					hdr_idx = '0;
					if (magic != MAGIC_VALUE) begin
						have = 1'b1;
						fin = 1'b1;
						st = ST_MAGIC;
					end else if (packets_left == 0) begin
						have = 1'b1;
						fin = 1'b1;
						st = size_verdict();
					end else begin
						phase = PH_CONTROL;
					end
				end else begin
					hdr_idx = hdr_idx + 4'd1;
				end
			end
			PH_CONTROL: begin
				packets_left = packets_left - 32'd1;
				run_left = 8'(b[LEN_BITS-1:0]) + 8'd1;
				if (b[LEN_BITS]) begin
					phase = PH_REPEAT;
				end else if (size_made >= size_goal) begin
					have = 1'b1;
					fin = 1'b1;
					st = ST_OVERFLOW;
				end else begin
					phase = PH_LITERAL;
				end
			end
			PH_LITERAL: begin
				if (size_made >= size_goal) begin
					have = 1'b1;
					fin = 1'b1;
					st = ST_OVERFLOW;
				end else begin
					have = 1'b1;
					tok.value = b;
					tok.count = 8'd1;
					size_made = size_made + 64'd1;
					run_left = run_left - 8'd1;
					if (run_left == 0) begin
						if (packets_left == 0) begin
							fin = 1'b1;
							st = size_verdict();
						end else begin
							phase = PH_CONTROL;
						end
					end
				end
			end
			PH_REPEAT: begin
				room = size_goal - size_made;
				have = 1'b1;
				if (room == 0) begin
					fin = 1'b1;
					st = ST_OVERFLOW;
				end else if (room < {56'd0, run_left}) begin
					// clip the run to what the original size still allows
					tok.value = b;
					tok.count = room[7:0];
					size_made = size_made + room;
					fin = 1'b1;
					st = ST_OVERFLOW;
				end else begin
					tok.value = b;
					tok.count = run_left;
					size_made = size_made + {56'd0, run_left};
					if (packets_left == 0) begin
						fin = 1'b1;
						st = size_verdict();
					end else begin
						phase = PH_CONTROL;
					end
				end
				run_left = '0;
			end
			default: ;
		endcase
		// end of file on a byte that does not close the file is a truncation
		if (eof && phase != PH_DRAIN && !fin) begin
			have = 1'b1;
			fin = 1'b1;
			st = ST_TRUNC;
		end
		if (eof)
			clear_state();
		else if (fin)
			phase = PH_DRAIN;
		if (have) begin
			tok.status = st;
			tok.finished = fin;
			tokens_due.push_back(tok);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_ports
		result_t want;
		if (!arst_n) begin
			clear_state();
			tokens_due.delete();
		end else begin
			// results first: a byte taken at this edge still has the input and result registers to pass
			if (out_valid && out_ready) begin
				seen_n++;
				if (tokens_due.size() == 0) begin
					bad_n++;
					if (bad_n <= 10)
						$display("%0t: unexpected token value=%02h count=%0d status=%0d finished=%0d",
							$realtime, out_value, out_count, status, finished);
				end else begin
					want = tokens_due.pop_front();
					if (out_value !== want.value || out_count !== want.count ||
						status !== want.status || finished !== want.finished) begin
						bad_n++;
						if (bad_n <= 10)
							$display({"%0t: token %0d mismatch: expected value=%02h count=%0d",
								" status=%0d finished=%0d, got value=%02h count=%0d status=%0d",
								" finished=%0d"}, $realtime, seen_n, want.value, want.count,
								want.status, want.finished, out_value, out_count, status, finished);
					end
				end
			end
			if (in_valid && in_ready)
				decode_byte(in_byte, end_of_file);
		end
		mismatches <= bad_n;
		tokens_due_n <= tokens_due.size();
		tokens_seen <= seen_n;
	end

endmodule

>>> sim/rle_packet_decoder_tb.sv
// Testbench top for the run-length packet decoder: builds compressed files, drives them
// byte by byte with random idling on both sides and gives the verdict.
// Depends on rled_pkg, rle_packet_decoder and rled_stream_checker.
`timescale 1ns / 1ps

module rle_packet_decoder_tb;
	import rled_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_BYTES = 80;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'd0;
	logic       end_of_file = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_value;
	logic [7:0] out_count;
	logic [2:0] status;
	logic       finished;

	int mismatches;
	int tokens_due_n;
	int tokens_seen;
	int send_idle = 0;
	int recv_stall = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int quiet = 0;
	int send_pct[4] = '{0, 87, 0, 15};
	int stall_pct[4] = '{0, 0, 87, 15};
	logic [8:0] file_q[$];

	rle_packet_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_file(end_of_file),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_value  (out_value),
		.out_count  (out_count),
		.status     (status),
		.finished   (finished)
	);

	rled_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.out_count   (out_count),
		.status      (status),
		.finished    (finished),
		.mismatches  (mismatches),
		.tokens_due_n(tokens_due_n),
		.tokens_seen (tokens_seen)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic eof);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		end_of_file <= eof;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		file_q.push_back({1'b0, b});
	endtask

	task automatic add_header(input logic [31:0] m, input logic [31:0] p, input logic [63:0] s);
		logic [127:0] h;
		h = {s, p, m};
		for (int i = 0; i < 16; i++)
			add_byte(h[8 * i +: 8]);
	endtask

	task automatic add_lit(input int n);
		add_byte({1'b0, 7'(n - 1)});
		repeat (n) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_rep(input int n, input logic [7:0] v);
		add_byte({1'b1, 7'(n - 1)});
		add_byte(v);
	endtask

	task automatic drop_tail(input int n);
		repeat (n) file_q.delete(file_q.size() - 1);
	endtask

	// Mark the last queued byte as end of file and stream the whole file out.
	task automatic send_file();
		file_q[file_q.size() - 1] = file_q[file_q.size() - 1] | 9'h100;
		foreach (file_q[i])
			put_byte(file_q[i][7:0], file_q[i][8]);
		file_q.delete();
		files_sent++;
	endtask

	// Mostly well-formed files; a share with a wrong size, bad magic, odd packet
	// count, junk after the end or an early end of file.
	task automatic random_file();
		int          npk;
		int          n;
		int          total;
		int          pick;
		logic [31:0] magic;
		logic [31:0] pkts;
		logic [63:0] size;
		int          run_len[$];
		bit          run_rep[$];
		npk = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 5);
		total = 0;
		for (int i = 0; i < npk; i++) begin
			run_rep.push_back(1'($urandom_range(0, 1)));
			case ($urandom_range(0, 19))
				0: n = 128;
				1, 2: n = run_rep[i] ? $urandom_range(7, 128) : $urandom_range(7, 24);
				default: n = $urandom_range(1, 6);
			endcase
			run_len.push_back(n);
			total += n;
		end
		magic = MAGIC_VALUE;
		pkts = npk;
		size = 64'(total);
		pick = $urandom_range(0, 99);
		if (pick < 12)
			size = $urandom_range(0, 1) ? size + 64'($urandom_range(1, 200))
				: {$urandom, $urandom};
		else if (pick < 24 && total > 0)
			size = 64'($urandom_range(0, total - 1));
		else if (pick < 30)
			magic = $urandom_range(0, 1) ? magic ^ (32'd1 << $urandom_range(0, 31)) : $urandom;
		else if (pick < 35)
			pkts = $urandom_range(0, 1) ? npk + 1 : $urandom;
		add_header(magic, pkts, size);
		for (int i = 0; i < npk; i++) begin
			if (run_rep[i])
				add_rep(run_len[i], 8'($urandom_range(0, 255)));
			else
				add_lit(run_len[i]);
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			drop_tail($urandom_range(1, file_q.size() - 1));
		send_file();
	endtask

	initial begin
		int target;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty files: sizes match, then a size that can never be reached
		add_header(MAGIC_VALUE, 32'd0, 64'd0);
		send_file();
		add_header(MAGIC_VALUE, 32'd0, '1);
		send_file();
		// bad magic, then bytes that must be ignored
		add_header('1, '1, '1);
		add_byte(8'hFF);
		add_byte(8'h00);
		send_file();
		// literal run of extreme bytes, full-length repeat, exact size
		add_header(MAGIC_VALUE, 32'd2, 64'd131);
		add_byte(8'h02);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h80);
		add_rep(128, 8'hFF);
		send_file();
		// literal control byte with nothing left to produce
		add_header(MAGIC_VALUE, 32'd1, 64'd0);
		add_byte(8'h00);
		add_byte(8'h7F);
		send_file();
		// repeat clipped to the remaining size
		add_header(MAGIC_VALUE, 32'd1, 64'd5);
		add_rep(10, 8'h5A);
		send_file();
		// repeat with no room left at all
		add_header(MAGIC_VALUE, 32'd2, 64'd2);
		add_lit(2);
		add_rep(1, 8'h11);
		send_file();
		// literal byte past the original size
		add_header(MAGIC_VALUE, 32'd1, 64'd1);
		add_lit(3);
		send_file();
		// last token comes up short of the original size
		add_header(MAGIC_VALUE, 32'd1, 64'd10);
		add_rep(4, 8'hC3);
		send_file();
		// early end of file: inside the header, on its last byte, mid literal run,
		// on a literal control byte, on a repeat control byte, one-byte file
		add_header(MAGIC_VALUE, 32'd1, 64'd1);
		drop_tail(9);
		send_file();
		add_header(MAGIC_VALUE, 32'd1, 64'd10);
		send_file();
		add_header(MAGIC_VALUE, 32'd3, 64'd100);
		add_lit(5);
		drop_tail(2);
		send_file();
		add_header(MAGIC_VALUE, 32'd3, 64'd100);
		add_lit(1);
		add_byte(8'h05);
		send_file();
		add_header(MAGIC_VALUE, 32'd2, 64'd50);
		add_byte(8'h83);
		send_file();
		add_byte(8'hA5);
		send_file();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = send_pct[ph];
			recv_stall = stall_pct[ph];
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target)
				random_file();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_due_n != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("run covered %0d files in %0d bytes, %0d result tokens checked",
			files_sent, bytes_sent, tokens_seen);
		$display("idling phases: none, sender 87%%, receiver 87%%, both 15%%");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
design/rled_pkg.sv
design/rled_core.sv
design/rle_packet_decoder.sv
sim/rled_stream_checker.sv
sim/rle_packet_decoder_tb.sv
